// File: rtl/npq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npq_pkg: shared types and palette constants
// Palette tables and the token that moves down the cell chain.
// ----------------------------------------------------------------------------
package npq_pkg;

    localparam int PaletteSize = 256;
    localparam int CubeBase    = 16;
    localparam int GreyBase    = 232;
    localparam int DistWidth   = 18;   // 3 * 255^2 fits in 18 bits

    localparam logic [DistWidth-1:0] DIST_MAX = '1;

    // Basic colours, {red, green, blue}
    localparam logic [23:0] BASIC_TAB [16] = '{
        24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
        24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
        24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
        24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
    };

    localparam logic [7:0] CUBE_LVL [6] = '{
        8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255
    };

    typedef struct packed {
        logic                 valid;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic [DistWidth-1:0] best_dist;
        logic [7:0]           best_index;
    } npq_token_t;

endpackage
`default_nettype wire

// File: rtl/npq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npq_cell: one palette entry of the search chain
// Measures the request's pixel against one entry and keeps the nearer one.
// ----------------------------------------------------------------------------
module npq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic [7:0]         entry_index,
    input  wire logic [23:0]        entry_color,
    input  wire npq_pkg::npq_token_t token_in,
    output npq_pkg::npq_token_t     token_out
);

    logic [7:0]                   diff_r;
    logic [7:0]                   diff_g;
    logic [7:0]                   diff_b;
    logic [15:0]                  sq_r;
    logic [15:0]                  sq_g;
    logic [15:0]                  sq_b;
    logic [npq_pkg::DistWidth-1:0] entry_dist;
    npq_pkg::npq_token_t          token_reg;
    npq_pkg::npq_token_t          token_next;

    always_comb
    begin
        diff_r = (token_in.red > entry_color[23:16]) ?
                 token_in.red - entry_color[23:16] : entry_color[23:16] - token_in.red;
        diff_g = (token_in.green > entry_color[15:8]) ?
                 token_in.green - entry_color[15:8] : entry_color[15:8] - token_in.green;
        diff_b = (token_in.blue > entry_color[7:0]) ?
                 token_in.blue - entry_color[7:0] : entry_color[7:0] - token_in.blue;
        sq_r = 16'(diff_r) * 16'(diff_r);
        sq_g = 16'(diff_g) * 16'(diff_g);
        sq_b = 16'(diff_b) * 16'(diff_b);
        entry_dist = npq_pkg::DistWidth'(sq_r) + npq_pkg::DistWidth'(sq_g)
                   + npq_pkg::DistWidth'(sq_b);

        token_next = token_in;
        // strict compare: an earlier entry keeps a tie
        if (entry_dist < token_in.best_dist)
        begin
            token_next.best_dist  = entry_dist;
            token_next.best_index = entry_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= '0;
        end
        else if (advance)
        begin
            token_reg <= token_next;
        end
    end

    assign token_out = token_reg;

endmodule
`default_nettype wire

// File: rtl/nearest_palette_color_quantizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_quantizer_core: RGB to 256-colour palette index
// Finds the nearest terminal palette entry by squared RGB distance.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with red, green, blue (8 bits each).
// Output channel: out_valid / out_stall with palette_index (8 bits); the
// lowest index wins when several entries are equally near.
// The search is a chain of 256 cells, one per palette entry, each holding
// one request and comparing it against its own entry every cycle.
// Throughput: one request per cycle while out_stall is low.
// When out_stall is high with a result waiting, the whole chain holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears every stage's valid bit; the chain is empty afterward and
// ready at once. The block keeps no state between requests.
// ----------------------------------------------------------------------------
module nearest_palette_color_quantizer_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      palette_index
);

    npq_pkg::npq_token_t chain [npq_pkg::PaletteSize+1];
    logic                advance;

    // hold the chain only when the last stage has a result nobody takes
    assign advance  = !(chain[npq_pkg::PaletteSize].valid && out_stall);
    assign in_stall = !advance;

    assign chain[0].valid      = in_valid;
    assign chain[0].red        = red;
    assign chain[0].green      = green;
    assign chain[0].blue       = blue;
    assign chain[0].best_dist  = npq_pkg::DIST_MAX;
    assign chain[0].best_index = 8'd0;

    for (genvar i = 0; i < npq_pkg::PaletteSize; i++)
    begin : g_cell
        localparam int BasicSel = (i < npq_pkg::CubeBase) ? i : 0;
        localparam int CubeV    = (i >= npq_pkg::CubeBase && i < npq_pkg::GreyBase) ?
                                  i - npq_pkg::CubeBase : 0;
        localparam int GreyStep = (i >= npq_pkg::GreyBase) ? i - npq_pkg::GreyBase : 0;
        localparam logic [7:0] GreyLvl = 8'(8 + GreyStep * 10);
        localparam logic [23:0] Color =
            (i < npq_pkg::CubeBase) ? npq_pkg::BASIC_TAB[BasicSel] :
            (i < npq_pkg::GreyBase) ? {npq_pkg::CUBE_LVL[(CubeV / 36) % 6],
                                        npq_pkg::CUBE_LVL[(CubeV / 6) % 6],
                                        npq_pkg::CUBE_LVL[CubeV % 6]} :
                                       {GreyLvl, GreyLvl, GreyLvl};

        npq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .entry_index (8'(i)),
            .entry_color (Color),
            .token_in    (chain[i]),
            .token_out   (chain[i+1])
        );
    end

    assign out_valid     = chain[npq_pkg::PaletteSize].valid;
    assign palette_index = chain[npq_pkg::PaletteSize].best_index;

endmodule
`default_nettype wire

// File: sim/tb_nearest_palette_color_quantizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_quantizer_core: palette quantizer testbench
// Drives RGB pixels through the valid/stall input channel and compares each
// palette index with a behavioral nearest-entry search over the 256-entry
// terminal palette. Covers exact palette colors, ties, random pixels, random
// and back-to-back flow, a long output hold that fills the chain, and a
// sender pause that drains it.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_quantizer_core;

    localparam int CLK_PERIOD    = 10;
    localparam int DRAIN_CYCLES  = 300;   // chain is 256 deep
    localparam int STALL_LIMIT   = 5000;  // cycles with no transfer on either side
    localparam int LONG_HOLD     = 700;
    localparam int IDLE_PERCENT  = 7;

    localparam logic [23:0] BASIC_COLORS [16] = '{
        24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
        24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
        24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
        24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
    };
    localparam logic [7:0] CUBE_LEVELS [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};
    // channel values on and between cube levels, where ties are likely
    localparam logic [7:0] LEVEL_EDGES [12] = '{
        8'd0, 8'd47, 8'd48, 8'd95, 8'd115, 8'd135,
        8'd155, 8'd175, 8'd195, 8'd215, 8'd235, 8'd255
    };

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] index;
    } quantized_pixel_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] palette_index;

    quantized_pixel_t expected_pixels[$];
    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  hold_remaining = 0;
    bit  sender_idles   = 1'b1;
    bit  receiver_idles = 1'b1;

    nearest_palette_color_quantizer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .palette_index (palette_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [23:0] palette_color(input int unsigned idx);
        int unsigned cube;
        logic [7:0]  grey;
        if (idx < 16)
        begin
            return BASIC_COLORS[idx];
        end
        else if (idx < 232)
        begin
            cube = idx - 16;
            return {CUBE_LEVELS[cube / 36], CUBE_LEVELS[(cube / 6) % 6], CUBE_LEVELS[cube % 6]};
        end
        grey = 8'(8 + (idx - 232) * 10);
        return {grey, grey, grey};
    endfunction

    function automatic int unsigned channel_dist(input logic [7:0] a, input logic [7:0] b);
        int unsigned d;
        d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        return d * d;
    endfunction

    // Exhaustive search; strict less-than keeps the lowest index on ties.
    function automatic logic [7:0] nearest_palette_index(input logic [7:0] r,
                                                         input logic [7:0] g,
                                                         input logic [7:0] b);
        int unsigned best_dist;
        int unsigned best_idx;
        int unsigned d;
        logic [23:0] c;
        best_dist = 32'hFFFF_FFFF;
        best_idx  = 0;
        for (int unsigned i = 0; i < 256; i++)
        begin
            c = palette_color(i);
            d = channel_dist(r, c[23:16]) + channel_dist(g, c[15:8]) + channel_dist(b, c[7:0]);
            if (d < best_dist)
            begin
                best_dist = d;
                best_idx  = i;
            end
        end
        return 8'(best_idx);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offer one pixel and hold it until accepted; record its expected index.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        quantized_pixel_t entry;
        while (sender_idles && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        do
            @(posedge clk);
        while (in_stall);
        entry.red   = r;
        entry.green = g;
        entry.blue  = b;
        entry.index = nearest_palette_index(r, g, b);
        expected_pixels.insert(expected_pixels.size(), entry);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] jitter_channel(input logic [7:0] v);
        int t;
        t = int'(v) + int'($urandom_range(12)) - 6;
        if (t < 0)
            t = 0;
        if (t > 255)
            t = 255;
        return 8'(t);
    endfunction

    task automatic send_random_pixel();
        logic [23:0] c;
        case ($urandom_range(3))
            0, 1:
            begin
                c = 24'($urandom);
            end
            2:
            begin
                c = palette_color($urandom_range(255));
                c = {jitter_channel(c[23:16]), jitter_channel(c[15:8]), jitter_channel(c[7:0])};
            end
            default:
            begin
                c = {LEVEL_EDGES[$urandom_range(11)], LEVEL_EDGES[$urandom_range(11)],
                     LEVEL_EDGES[$urandom_range(11)]};
            end
        endcase
        send_pixel(c[23:16], c[15:8], c[7:0]);
    endtask

    task automatic wait_for_drain();
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Exact palette colors, duplicates, ramp ends, ties and channel extremes.
    task automatic test_directed_colors();
        for (int i = 0; i < 16; i++)
            send_pixel(BASIC_COLORS[i][23:16], BASIC_COLORS[i][15:8], BASIC_COLORS[i][7:0]);
        send_pixel(8'd8, 8'd8, 8'd8);
        send_pixel(8'd238, 8'd238, 8'd238);
        send_pixel(8'd13, 8'd13, 8'd13);       // midway between two grey steps
        send_pixel(8'd115, 8'd115, 8'd115);    // midway between two cube levels
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd95, 8'd135, 8'd175);
        send_pixel(8'd1, 8'd2, 8'd3);
        send_pixel(8'd254, 8'd254, 8'd254);
        send_pixel(8'd170, 8'd85, 8'd170);
        end_burst();
    endtask

    task automatic test_random_pixels();
        for (int i = 0; i < 105; i++)
            send_random_pixel();
        end_burst();
    endtask

    task automatic test_back_to_back();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        for (int i = 0; i < 120; i++)
            send_random_pixel();
        end_burst();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // Hold the output long enough that the chain fills and stalls the input.
    task automatic test_output_hold();
        sender_idles   = 1'b0;
        hold_remaining = LONG_HOLD;
        for (int i = 0; i < 300; i++)
            send_random_pixel();
        end_burst();
        sender_idles = 1'b1;
    endtask

    task automatic test_sender_pause();
        for (int i = 0; i < 25; i++)
            send_random_pixel();
        end_burst();
        wait_for_drain();
        for (int i = 0; i < 25; i++)
            send_random_pixel();
        end_burst();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_remaining > 0)
        begin
            out_stall <= 1'b1;
            hold_remaining--;
        end
        else
        begin
            out_stall <= receiver_idles && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        quantized_pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("palette_index %0d with no request pending",
                                          palette_index));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (palette_index !== want.index)
                    report_mismatch($sformatf("rgb %0d,%0d,%0d: palette_index %0d, want %0d",
                                              want.red, want.green, want.blue,
                                              palette_index, want.index));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("nearest_palette_color_quantizer_core verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        red       <= 8'd0;
        green     <= 8'd0;
        blue      <= 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_colors();
        test_random_pixels();
        test_back_to_back();
        test_output_hold();
        test_sender_pause();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("nearest_palette_color_quantizer_core verification clean");
        else
            $display("nearest_palette_color_quantizer_core verification failed");
        $finish;
    end

endmodule
